[src/unicode_character_counter_assert.svh]
// Assertion macros for the character counter.
// Included by modules that carry concurrent checks; needs no package.
`ifndef UNICODE_CHARACTER_COUNTER_ASSERT_SVH
`define UNICODE_CHARACTER_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucc assertion failed");

// Next-cycle implication, disabled during reset.
`define UCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucc assertion failed");

`endif

[src/ucc_pkg.sv]
// Shared types and constants for the character counter.
// No dependencies.
package ucc_pkg;

  // encoding register codes
  localparam logic [2:0] ENC_NONE    = 3'd0;
  localparam logic [2:0] ENC_UTF8    = 3'd1;
  localparam logic [2:0] ENC_UTF16LE = 3'd2;
  localparam logic [2:0] ENC_UTF16BE = 3'd3;
  localparam logic [2:0] ENC_UTF32LE = 3'd4;
  localparam logic [2:0] ENC_UTF32BE = 3'd5;
  localparam logic [2:0] ENC_UNKNOWN = 3'd6;

  typedef enum logic [1:0] {
    FAM_UTF8,
    FAM_UTF16,
    FAM_UTF32
  } fam_t;

  // counter indexes
  localparam int NUM_CLS = 5;
  localparam logic [2:0] CLS_SINGLE  = 3'd0;
  localparam logic [2:0] CLS_DOUBLE  = 3'd1;
  localparam logic [2:0] CLS_TRIPLE  = 3'd2;
  localparam logic [2:0] CLS_QUAD    = 3'd3;
  localparam logic [2:0] CLS_INVALID = 3'd4;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [15:0] LEAD_LO  = 16'hD800;
  localparam logic [15:0] LEAD_HI  = 16'hDBFF;
  localparam logic [15:0] TRAIL_LO = 16'hDC00;
  localparam logic [15:0] TRAIL_HI = 16'hDFFF;
  localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;
  localparam logic [31:0] ASCII_MAX = 32'h0000_007F;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_LEFT  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic mark;
    logic decide;
    logic add_left;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic at_start;
    logic last;
    logic full;
    logic unit_ok;
    logic stop;
    logic out_free;
  } sts_t;

endpackage

[src/ucc_ifs.sv]
// Valid/ready channel interfaces for the character counter.
// No dependencies.
interface ucc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface ucc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] single_unit_chars;
  logic [31:0] double_unit_chars;
  logic [31:0] triple_unit_chars;
  logic [31:0] quad_unit_chars;
  logic [31:0] invalid_count;
  logic [2:0]  mark_bytes;
  modport source (output valid, single_unit_chars, double_unit_chars, triple_unit_chars,
                  quad_unit_chars, invalid_count, mark_bytes, input ready);
  modport sink   (input valid, single_unit_chars, double_unit_chars, triple_unit_chars,
                  quad_unit_chars, invalid_count, mark_bytes, output ready);
endinterface

[src/ucc_ctrl.sv]
// Sequencer for the character counter: one step per cycle, holding in the emit step while a result is still pending.
// Depends on ucc_pkg and unicode_character_counter_assert.svh.
`include "unicode_character_counter_assert.svh"

module ucc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ucc_pkg::sts_t sts,
  output ucc_pkg::cmd_t cmd
);

  ucc_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ucc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ucc_pkg::ST_CHECK;
        end
      end
      ucc_pkg::ST_CHECK: begin
        cmd.mark  = sts.at_start && (sts.full || sts.last);
        state_nxt = sts.last ? ucc_pkg::ST_FLUSH : ucc_pkg::ST_STEP;
      end
      ucc_pkg::ST_STEP: begin
        cmd.decide = !sts.at_start && sts.full;
        state_nxt  = ucc_pkg::ST_IDLE;
      end
      ucc_pkg::ST_FLUSH: begin
        if (sts.unit_ok) begin
          cmd.decide = 1'b1;
          // lone lead surrogate at the end stops the flush
          if (sts.stop) state_nxt = ucc_pkg::ST_LEFT;
        end else begin
          state_nxt = ucc_pkg::ST_LEFT;
        end
      end
      ucc_pkg::ST_LEFT: begin
        cmd.add_left = 1'b1;
        state_nxt    = ucc_pkg::ST_EMIT;
      end
      ucc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ucc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ucc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ucc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `UCC_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free)
  `UCC_ASSERT_NXT(a_load_busy, clk, rst_n, cmd.load, !in_ready)
  `UCC_ASSERT_NXT(a_flush_ends, clk, rst_n, state_r == ucc_pkg::ST_FLUSH && !sts.unit_ok, state_r == ucc_pkg::ST_LEFT)
  `UCC_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $countones(cmd) <= 1)

endmodule

[src/ucc_dp.sv]
// Datapath for the character counter: window, mark check, decoder,
// saturating counters and output register. Depends on ucc_pkg.
module ucc_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ucc_pkg::cmd_t cmd,
  output ucc_pkg::sts_t sts,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_wdata,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [31:0]   out_single,
  output logic [31:0]   out_double,
  output logic [31:0]   out_triple,
  output logic [31:0]   out_quad,
  output logic [31:0]   out_invalid,
  output logic [2:0]    out_mark
);

  logic [2:0] enc_r;
  logic [7:0] win_r [4];
  logic [7:0] win_nxt [4];
  logic [2:0] fill_r, fill_nxt;
  logic       at_start_r, at_start_nxt;
  logic       last_r, last_nxt;
  logic [2:0] mark_r, mark_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r   [ucc_pkg::NUM_CLS];
  logic [COUNT_WIDTH-1:0] cnt_nxt [ucc_pkg::NUM_CLS];
  logic [31:0] clip [ucc_pkg::NUM_CLS];
  logic [31:0] out_cnt_r [ucc_pkg::NUM_CLS];
  logic [2:0]  out_mark_r;
  logic        out_valid_r, out_valid_nxt;

  ucc_pkg::fam_t fam;
  logic [2:0]  min_unit;
  logic [2:0]  dec_cls;
  logic [2:0]  dec_n;
  logic [2:0]  mark_len;
  logic [2:0]  drop_n;
  logic [15:0] u16, v16;
  logic [31:0] c32;
  logic [31:0] flat, shifted;
  logic        c1, c2, c3;

  // encoding family
  always_comb begin
    case (enc_r)
      ucc_pkg::ENC_UTF16LE, ucc_pkg::ENC_UTF16BE: fam = ucc_pkg::FAM_UTF16;
      ucc_pkg::ENC_UTF32LE, ucc_pkg::ENC_UTF32BE: fam = ucc_pkg::FAM_UTF32;
      ucc_pkg::ENC_NONE, ucc_pkg::ENC_UTF8, ucc_pkg::ENC_UNKNOWN: fam = ucc_pkg::FAM_UTF8;
      default: fam = ucc_pkg::FAM_UTF8;
    endcase
    case (fam)
      ucc_pkg::FAM_UTF16: min_unit = 3'd2;
      ucc_pkg::FAM_UTF32: min_unit = 3'd4;
      default:            min_unit = 3'd1;
    endcase
  end

  // byte-order mark
  always_comb begin
    mark_len = 3'd0;
    case (enc_r)
      ucc_pkg::ENC_UTF8:
        if (fill_r >= 3'd3 && win_r[0] == 8'hEF && win_r[1] == 8'hBB && win_r[2] == 8'hBF)
          mark_len = 3'd3;
      ucc_pkg::ENC_UTF16LE:
        if (fill_r >= 3'd2 && win_r[0] == 8'hFF && win_r[1] == 8'hFE) mark_len = 3'd2;
      ucc_pkg::ENC_UTF16BE:
        if (fill_r >= 3'd2 && win_r[0] == 8'hFE && win_r[1] == 8'hFF) mark_len = 3'd2;
      ucc_pkg::ENC_UTF32LE:
        if (fill_r == 3'd4 && win_r[0] == 8'hFF && win_r[1] == 8'hFE &&
            win_r[2] == 8'h00 && win_r[3] == 8'h00) mark_len = 3'd4;
      ucc_pkg::ENC_UTF32BE:
        if (fill_r == 3'd4 && win_r[0] == 8'h00 && win_r[1] == 8'h00 &&
            win_r[2] == 8'hFE && win_r[3] == 8'hFF) mark_len = 3'd4;
      default: mark_len = 3'd0;
    endcase
  end

  // one decision on the bytes held; avail equals the fill level
  always_comb begin
    c1  = (win_r[1] & ucc_pkg::CONT_MASK) == ucc_pkg::CONT_TAG;
    c2  = (win_r[2] & ucc_pkg::CONT_MASK) == ucc_pkg::CONT_TAG;
    c3  = (win_r[3] & ucc_pkg::CONT_MASK) == ucc_pkg::CONT_TAG;
    u16 = (enc_r == ucc_pkg::ENC_UTF16LE) ? {win_r[1], win_r[0]} : {win_r[0], win_r[1]};
    v16 = (enc_r == ucc_pkg::ENC_UTF16LE) ? {win_r[3], win_r[2]} : {win_r[2], win_r[3]};
    c32 = (enc_r == ucc_pkg::ENC_UTF32LE) ? {win_r[3], win_r[2], win_r[1], win_r[0]}
                                          : {win_r[0], win_r[1], win_r[2], win_r[3]};
    dec_cls = ucc_pkg::CLS_INVALID;
    dec_n   = 3'd1;
    case (fam)
      ucc_pkg::FAM_UTF16: begin
        if (u16 >= ucc_pkg::LEAD_LO && u16 <= ucc_pkg::LEAD_HI) begin
          if (fill_r == 3'd4) begin
            if (v16 >= ucc_pkg::TRAIL_LO && v16 <= ucc_pkg::TRAIL_HI) begin
              dec_cls = ucc_pkg::CLS_DOUBLE;
              dec_n   = 3'd4;
            end
          end else begin
            dec_n = 3'd0;
          end
        end else if (u16 >= ucc_pkg::TRAIL_LO && u16 <= ucc_pkg::TRAIL_HI) begin
          dec_n = 3'd1;
        end else if ({16'd0, u16} <= ucc_pkg::ASCII_MAX) begin
          dec_cls = ucc_pkg::CLS_SINGLE;
          dec_n   = 3'd2;
        end else begin
          dec_cls = ucc_pkg::CLS_DOUBLE;
          dec_n   = 3'd2;
        end
      end
      ucc_pkg::FAM_UTF32: begin
        if (!((c32 >= {16'd0, ucc_pkg::LEAD_LO} && c32 <= {16'd0, ucc_pkg::TRAIL_HI}) ||
              c32 > ucc_pkg::CP_MAX)) begin
          dec_cls = (c32 <= ucc_pkg::ASCII_MAX) ? ucc_pkg::CLS_SINGLE : ucc_pkg::CLS_QUAD;
          dec_n   = 3'd4;
        end
      end
      default: begin
        if (!win_r[0][7]) begin
          dec_cls = ucc_pkg::CLS_SINGLE;
        end else if (win_r[0][7:5] == 3'b110) begin
          if (fill_r >= 3'd2 && c1) begin
            dec_cls = ucc_pkg::CLS_DOUBLE;
            dec_n   = 3'd2;
          end
        end else if (win_r[0][7:4] == 4'b1110) begin
          if (fill_r >= 3'd3 && c1 && c2) begin
            dec_cls = ucc_pkg::CLS_TRIPLE;
            dec_n   = 3'd3;
          end
        end else if (fill_r == 3'd4 && c1 && c2 && c3) begin
          dec_cls = ucc_pkg::CLS_QUAD;
          dec_n   = 3'd4;
        end
      end
    endcase
  end

  assign drop_n = cmd.mark ? mark_len : (cmd.decide ? dec_n : 3'd0);
  assign flat   = {win_r[3], win_r[2], win_r[1], win_r[0]};
  assign shifted = flat >> {drop_n, 3'b000};

  always_comb begin
    logic [2:0]           add_n;
    logic [COUNT_WIDTH:0] sum;
    for (int i = 0; i < 4; i++) win_nxt[i] = win_r[i];
    fill_nxt     = fill_r;
    at_start_nxt = at_start_r;
    last_nxt     = last_r;
    mark_nxt     = mark_r;
    if (cmd.load) begin
      win_nxt[fill_r[1:0]] = in_data_byte;
      fill_nxt             = fill_r + 3'd1;
      last_nxt             = in_last;
    end
    if (cmd.mark || cmd.decide) begin
      for (int i = 0; i < 4; i++) win_nxt[i] = shifted[8*i +: 8];
      fill_nxt = fill_r - drop_n;
    end
    if (cmd.mark) begin
      mark_nxt     = mark_len;
      at_start_nxt = 1'b0;
    end
    for (int k = 0; k < ucc_pkg::NUM_CLS; k++) begin
      add_n = 3'd0;
      if (cmd.decide && dec_cls == 3'(k)) add_n = 3'd1;
      if (cmd.add_left && ucc_pkg::CLS_INVALID == 3'(k)) add_n = fill_r;
      sum = {1'b0, cnt_r[k]} + (COUNT_WIDTH+1)'(add_n);
      cnt_nxt[k] = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    end
    // result loaded into the output register: back to start-of-buffer state
    if (cmd.emit) begin
      for (int i = 0; i < 4; i++) win_nxt[i] = 8'h00;
      fill_nxt     = 3'd0;
      at_start_nxt = 1'b1;
      mark_nxt     = 3'd0;
      for (int k = 0; k < ucc_pkg::NUM_CLS; k++) cnt_nxt[k] = '0;
    end
    if (cmd.emit)          out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  // clip counts to the 32-bit result fields
  for (genvar k = 0; k < ucc_pkg::NUM_CLS; k++) begin : g_clip
    if (COUNT_WIDTH > 32) begin : g_wide
      assign clip[k] = (|cnt_r[k][COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : cnt_r[k][31:0];
    end else begin : g_narrow
      assign clip[k] = 32'(cnt_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r       <= ucc_pkg::ENC_NONE;
      for (int i = 0; i < 4; i++) win_r[i] <= 8'h00;
      fill_r      <= 3'd0;
      at_start_r  <= 1'b1;
      mark_r      <= 3'd0;
      for (int k = 0; k < ucc_pkg::NUM_CLS; k++) cnt_r[k] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) enc_r <= cfg_wdata;
      for (int i = 0; i < 4; i++) win_r[i] <= win_nxt[i];
      fill_r      <= fill_nxt;
      at_start_r  <= at_start_nxt;
      mark_r      <= mark_nxt;
      for (int k = 0; k < ucc_pkg::NUM_CLS; k++) cnt_r[k] <= cnt_nxt[k];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    if (cmd.emit) begin
      for (int k = 0; k < ucc_pkg::NUM_CLS; k++) out_cnt_r[k] <= clip[k];
      out_mark_r <= mark_r;
    end
  end

  always_comb begin
    sts.at_start = at_start_r;
    sts.last     = last_r;
    sts.full     = fill_r == 3'd4;
    sts.unit_ok  = fill_r >= min_unit;
    sts.stop     = dec_n == 3'd0;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_single  = out_cnt_r[ucc_pkg::CLS_SINGLE];
  assign out_double  = out_cnt_r[ucc_pkg::CLS_DOUBLE];
  assign out_triple  = out_cnt_r[ucc_pkg::CLS_TRIPLE];
  assign out_quad    = out_cnt_r[ucc_pkg::CLS_QUAD];
  assign out_invalid = out_cnt_r[ucc_pkg::CLS_INVALID];
  assign out_mark    = out_mark_r;

endmodule

[src/unicode_character_counter.sv]
// Top level of the character counter: controller plus datapath.
// Depends on ucc_pkg, ucc_ifs (ucc_in_if, ucc_out_if), ucc_ctrl, ucc_dp.
//
// Usage:
//  - in_ch carries one byte of a buffer per item, with last set on the
//    final byte. out_ch carries one item per buffer: the five character
//    counts (saturating) and the length of the skipped byte-order mark.
//  - cfg_we/cfg_wdata write the encoding register (0 none, 1 UTF-8,
//    2/3 UTF-16LE/BE, 4/5 UTF-32LE/BE, 6 unknown); write it while idle.
//  - A non-final byte steps through accept, mark check and at most one
//    decision. The sequencer issues at most one window operation per cycle.
//  - The final byte steps through accept, mark check, d flush decisions,
//    flush exit, leftover count and result load, where d (0..4) is the
//    number of decisions in the flush; a lone lead surrogate ends the flush
//    on its decision, with no flush exit. The result load waits while a
//    result is still pending; the result is valid the cycle after it.
//  - The result sits in an output register: while the receiver stalls,
//    the next buffer is already taken in; only a second result waits.
//  - Reset (rst_n low, synchronous) clears the window, counts and mark,
//    sets the encoding to none and drops any pending result.
module unicode_character_counter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ucc_in_if.sink     in_ch,
  ucc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata
);

  ucc_pkg::cmd_t cmd;
  ucc_pkg::sts_t sts;
  logic          in_ready;

  ucc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ucc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data_byte (in_ch.data_byte),
    .in_last      (in_ch.last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_single   (out_ch.single_unit_chars),
    .out_double   (out_ch.double_unit_chars),
    .out_triple   (out_ch.triple_unit_chars),
    .out_quad     (out_ch.quad_unit_chars),
    .out_invalid  (out_ch.invalid_count),
    .out_mark     (out_ch.mark_bytes)
  );

  assign in_ch.ready = in_ready;

endmodule

[bench/tb_top.sv]
// Self-checking bench for unicode_character_counter: byte buffers in, count items out.
// Depends on ucc_pkg, ucc_ifs (ucc_in_if, ucc_out_if) and the counter RTL.
// Own model of the counter predicts every result; directed buffers, then random ones.
module tb_top;

  // register value beyond the defined codes; decodes as UTF-8
  localparam logic [2:0] ENC_UNDEF = 3'd7;
  localparam logic [2:0] ENC_CODES [8] = '{ucc_pkg::ENC_NONE, ucc_pkg::ENC_UTF8,
                                           ucc_pkg::ENC_UTF16LE, ucc_pkg::ENC_UTF16BE,
                                           ucc_pkg::ENC_UTF32LE, ucc_pkg::ENC_UTF32BE,
                                           ucc_pkg::ENC_UNKNOWN, ENC_UNDEF};
  localparam int RANDOM_BYTES  = 1900;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [31:0] single_chars;
    logic [31:0] double_chars;
    logic [31:0] triple_chars;
    logic [31:0] quad_chars;
    logic [31:0] invalid_bytes;
    logic [2:0]  mark_len;
  } counts_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  ucc_in_if  in_ch ();
  ucc_out_if out_ch ();

  unicode_character_counter #(.COUNT_WIDTH(32)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------- counter model ----------------
  logic [7:0]  win_bytes [4];
  int unsigned win_fill;
  bit          buf_at_start;
  logic [31:0] char_totals [ucc_pkg::NUM_CLS];
  logic [2:0]  mark_seen_len;
  logic [2:0]  model_enc;

  counts_t     expected_counts [$];
  logic [7:0]  buf_bytes [$];
  int          mismatches;
  int          cycle_count;
  bit          sender_gaps;
  bit          receiver_stalls;
  int          stall_left;

  function automatic void clear_buffer_state();
    foreach (win_bytes[i]) win_bytes[i] = 8'h00;
    foreach (char_totals[i]) char_totals[i] = '0;
    win_fill      = 0;
    buf_at_start  = 1'b1;
    mark_seen_len = '0;
  endfunction

  function automatic ucc_pkg::fam_t family_of(input logic [2:0] enc);
    case (enc)
      ucc_pkg::ENC_UTF16LE, ucc_pkg::ENC_UTF16BE: return ucc_pkg::FAM_UTF16;
      ucc_pkg::ENC_UTF32LE, ucc_pkg::ENC_UTF32BE: return ucc_pkg::FAM_UTF32;
      default: return ucc_pkg::FAM_UTF8;
    endcase
  endfunction

  function automatic void bump(input logic [2:0] cls, input int unsigned n);
    logic [32:0] sum;
    sum = {1'b0, char_totals[cls]} + 33'(n);
    char_totals[cls] = sum[32] ? '1 : sum[31:0];
  endfunction

  function automatic void drop_front(input int unsigned n);
    int unsigned k;
    k = (n > win_fill) ? win_fill : n;
    for (int i = 0; i < 4; i++) begin
      win_bytes[i] = (i + k < 4) ? win_bytes[i + k] : 8'h00;
    end
    win_fill -= k;
  endfunction

  function automatic bit is_cont(input logic [7:0] b);
    return (b & ucc_pkg::CONT_MASK) == ucc_pkg::CONT_TAG;
  endfunction

  function automatic logic [15:0] unit16_at(input int k);
    if (model_enc == ucc_pkg::ENC_UTF16LE) begin
      return {win_bytes[k + 1], win_bytes[k]};
    end
    return {win_bytes[k], win_bytes[k + 1]};
  endfunction

  // one decision on the front of the window; 0 = lone lead surrogate at the end
  function automatic int unsigned decide_unit(input int unsigned avail);
    logic [7:0]  b;
    logic [15:0] u;
    logic [15:0] v;
    logic [31:0] c;
    b = win_bytes[0];
    case (family_of(model_enc))
      ucc_pkg::FAM_UTF8: begin
        if (!b[7]) begin
          bump(ucc_pkg::CLS_SINGLE, 1);
          return 1;
        end
        if ((b & 8'hE0) == 8'hC0) begin
          if (avail >= 2 && is_cont(win_bytes[1])) begin
            bump(ucc_pkg::CLS_DOUBLE, 1);
            return 2;
          end
        end else if ((b & 8'hF0) == 8'hE0) begin
          if (avail >= 3 && is_cont(win_bytes[1]) && is_cont(win_bytes[2])) begin
            bump(ucc_pkg::CLS_TRIPLE, 1);
            return 3;
          end
        end else if (avail >= 4 && is_cont(win_bytes[1]) && is_cont(win_bytes[2]) &&
                     is_cont(win_bytes[3])) begin
          bump(ucc_pkg::CLS_QUAD, 1);
          return 4;
        end
        bump(ucc_pkg::CLS_INVALID, 1);
        return 1;
      end
      ucc_pkg::FAM_UTF16: begin
        u = unit16_at(0);
        if (u >= ucc_pkg::LEAD_LO && u <= ucc_pkg::LEAD_HI) begin
          bump(ucc_pkg::CLS_INVALID, (avail >= 4) ? 0 : 1);
          if (avail < 4) return 0;
          v = unit16_at(2);
          if (v >= ucc_pkg::TRAIL_LO && v <= ucc_pkg::TRAIL_HI) begin
            bump(ucc_pkg::CLS_DOUBLE, 1);
            return 4;
          end
          bump(ucc_pkg::CLS_INVALID, 1);
          return 1;
        end
        if (u >= ucc_pkg::TRAIL_LO && u <= ucc_pkg::TRAIL_HI) begin
          bump(ucc_pkg::CLS_INVALID, 1);
          return 1;
        end
        bump(({16'h0, u} <= ucc_pkg::ASCII_MAX) ? ucc_pkg::CLS_SINGLE : ucc_pkg::CLS_DOUBLE,
             1);
        return 2;
      end
      default: begin
        if (model_enc == ucc_pkg::ENC_UTF32LE) begin
          c = {win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]};
        end else begin
          c = {win_bytes[0], win_bytes[1], win_bytes[2], win_bytes[3]};
        end
        if ((c >= {16'h0, ucc_pkg::LEAD_LO} && c <= {16'h0, ucc_pkg::TRAIL_HI}) ||
            c > ucc_pkg::CP_MAX) begin
          bump(ucc_pkg::CLS_INVALID, 1);
          return 1;
        end
        bump((c <= ucc_pkg::ASCII_MAX) ? ucc_pkg::CLS_SINGLE : ucc_pkg::CLS_QUAD, 1);
        return 4;
      end
    endcase
  endfunction

  // feed one accepted byte; returns 1 with the totals when the buffer ends
  function automatic bit predict_byte(input logic [7:0] data, input logic last,
                                      output counts_t res);
    int unsigned mlen;
    int unsigned n;
    int unsigned unit;
    res = '0;
    if (win_fill > 3) win_fill = 3;
    win_bytes[win_fill] = data;
    win_fill++;
    if (buf_at_start && (win_fill == 4 || last)) begin
      mlen = 0;
      case (model_enc)
        ucc_pkg::ENC_UTF8: begin
          if (win_fill >= 3 && win_bytes[0] == 8'hEF && win_bytes[1] == 8'hBB &&
              win_bytes[2] == 8'hBF) mlen = 3;
        end
        ucc_pkg::ENC_UTF16LE: begin
          if (win_fill >= 2 && win_bytes[0] == 8'hFF && win_bytes[1] == 8'hFE) mlen = 2;
        end
        ucc_pkg::ENC_UTF16BE: begin
          if (win_fill >= 2 && win_bytes[0] == 8'hFE && win_bytes[1] == 8'hFF) mlen = 2;
        end
        ucc_pkg::ENC_UTF32LE: begin
          if (win_fill >= 4 && win_bytes[0] == 8'hFF && win_bytes[1] == 8'hFE &&
              win_bytes[2] == 8'h00 && win_bytes[3] == 8'h00) mlen = 4;
        end
        ucc_pkg::ENC_UTF32BE: begin
          if (win_fill >= 4 && win_bytes[0] == 8'h00 && win_bytes[1] == 8'h00 &&
              win_bytes[2] == 8'hFE && win_bytes[3] == 8'hFF) mlen = 4;
        end
        default: ;
      endcase
      mark_seen_len = 3'(mlen);
      drop_front(mlen);
      buf_at_start = 1'b0;
    end
    if (!last) begin
      if (!buf_at_start && win_fill == 4) drop_front(decide_unit(4));
      return 1'b0;
    end
    case (family_of(model_enc))
      ucc_pkg::FAM_UTF16: unit = 2;
      ucc_pkg::FAM_UTF32: unit = 4;
      default:            unit = 1;
    endcase
    // end-of-buffer flush, leftovers count as invalid
    while (win_fill >= unit) begin
      n = decide_unit(win_fill);
      if (n == 0) break;
      drop_front(n);
    end
    bump(ucc_pkg::CLS_INVALID, win_fill);
    res.single_chars  = char_totals[ucc_pkg::CLS_SINGLE];
    res.double_chars  = char_totals[ucc_pkg::CLS_DOUBLE];
    res.triple_chars  = char_totals[ucc_pkg::CLS_TRIPLE];
    res.quad_chars    = char_totals[ucc_pkg::CLS_QUAD];
    res.invalid_bytes = char_totals[ucc_pkg::CLS_INVALID];
    res.mark_len      = mark_seen_len;
    clear_buffer_state();
    return 1'b1;
  endfunction

  // ---------------- stimulus helpers ----------------
  // idle length: mostly none, some short, a few long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_unit16(input logic [2:0] enc, input logic [15:0] u);
    if (enc == ucc_pkg::ENC_UTF16LE) begin
      buf_bytes.push_back(u[7:0]);
      buf_bytes.push_back(u[15:8]);
    end else begin
      buf_bytes.push_back(u[15:8]);
      buf_bytes.push_back(u[7:0]);
    end
  endfunction

  // a buffer of mostly well-formed characters for enc, with some noise
  function automatic void compose_buffer(input logic [2:0] enc);
    int          nchars;
    int          kind;
    int          sel;
    logic [15:0] u;
    logic [31:0] c;
    buf_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      case (enc)
        ucc_pkg::ENC_UTF16LE: buf_bytes = '{8'hFF, 8'hFE};
        ucc_pkg::ENC_UTF16BE: buf_bytes = '{8'hFE, 8'hFF};
        ucc_pkg::ENC_UTF32LE: buf_bytes = '{8'hFF, 8'hFE, 8'h00, 8'h00};
        ucc_pkg::ENC_UTF32BE: buf_bytes = '{8'h00, 8'h00, 8'hFE, 8'hFF};
        default:              buf_bytes = '{8'hEF, 8'hBB, 8'hBF};
      endcase
    end else if (kind == 4) begin
      buf_bytes = '{8'hFF, 8'hFE};
    end else if (kind == 5) begin
      buf_bytes = '{8'hEF, 8'hBB};
    end
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
    for (int i = 0; i < nchars; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        buf_bytes.push_back(8'($urandom));
        continue;
      end
      case (family_of(enc))
        ucc_pkg::FAM_UTF8: begin
          sel = kind % 6;
          case (sel)
            0: buf_bytes.push_back(8'($urandom_range(0, 127)));
            1, 2, 3: begin
              case (sel)
                1: buf_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                2: buf_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                default: buf_bytes.push_back(8'($urandom_range(8'hF0, 8'hFF)));
              endcase
              repeat (sel) buf_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            4: begin
              // lead cut short by an ASCII byte
              buf_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
              buf_bytes.push_back(8'($urandom_range(0, 127)));
            end
            default: buf_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          endcase
        end
        ucc_pkg::FAM_UTF16: begin
          sel = kind % 6;
          case (sel)
            0: push_unit16(enc, 16'($urandom_range(0, 127)));
            1: begin
              if ($urandom_range(0, 1) == 0) begin
                u = 16'($urandom_range(16'h0080, 16'hD7FF));
              end else begin
                u = 16'($urandom_range(16'hE000, 16'hFFFF));
              end
              push_unit16(enc, u);
            end
            2, 3: begin
              push_unit16(enc, 16'($urandom_range(ucc_pkg::LEAD_LO, ucc_pkg::LEAD_HI)));
              push_unit16(enc, 16'($urandom_range(ucc_pkg::TRAIL_LO, ucc_pkg::TRAIL_HI)));
            end
            4: push_unit16(enc, 16'($urandom_range(ucc_pkg::TRAIL_LO, ucc_pkg::TRAIL_HI)));
            default: begin
              push_unit16(enc, 16'($urandom_range(ucc_pkg::LEAD_LO, ucc_pkg::LEAD_HI)));
              push_unit16(enc, 16'($urandom_range(0, 16'hD7FF)));
            end
          endcase
        end
        default: begin
          sel = kind % 5;
          case (sel)
            0: c = 32'($urandom_range(0, 127));
            1, 2: begin
              c = 32'($urandom_range(32'h80, ucc_pkg::CP_MAX));
              if (c >= {16'h0, ucc_pkg::LEAD_LO} && c <= {16'h0, ucc_pkg::TRAIL_HI}) begin
                c = c - 32'h800;
              end
            end
            3: c = 32'($urandom_range(ucc_pkg::LEAD_LO, ucc_pkg::TRAIL_HI));
            default: c = 32'($urandom_range(32'h0011_0000, 32'hFFFF_FFFF));
          endcase
          if (enc == ucc_pkg::ENC_UTF32LE) begin
            buf_bytes.push_back(c[7:0]);
            buf_bytes.push_back(c[15:8]);
            buf_bytes.push_back(c[23:16]);
            buf_bytes.push_back(c[31:24]);
          end else begin
            buf_bytes.push_back(c[31:24]);
            buf_bytes.push_back(c[23:16]);
            buf_bytes.push_back(c[15:8]);
            buf_bytes.push_back(c[7:0]);
          end
        end
      endcase
    end
    if (buf_bytes.size() == 0) buf_bytes.push_back(8'($urandom));
  endfunction

  // drive one byte at the falling edge, hold until accepted, then predict
  task automatic push_byte(input logic [7:0] data, input logic last);
    int      gap;
    counts_t res;
    @(negedge clk);
    gap = pick_gap(sender_gaps);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = data;
    in_ch.last      = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_byte(data, last, res)) expected_counts.push_back(res);
  endtask

  task automatic send_buffer();
    foreach (buf_bytes[i]) push_byte(buf_bytes[i], i == buf_bytes.size() - 1);
  endtask

  // stop sending and wait until every expected item has come out
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_encoding(input logic [2:0] enc);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = enc;
    @(negedge clk);
    cfg_we    = 1'b0;
    model_enc = enc;
  endtask

  // ---------------- tests ----------------
  task automatic test_single_byte_buffers();
    set_encoding(ucc_pkg::ENC_NONE);
    buf_bytes = '{8'h00};
    send_buffer();
    buf_bytes = '{8'hFF};
    send_buffer();
  endtask

  task automatic test_utf8_lengths();
    set_encoding(ucc_pkg::ENC_UTF8);
    // mark, 1/2/3/4-byte characters, trailing invalid byte
    buf_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                  8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF};
    send_buffer();
  endtask

  task automatic test_utf16_lone_lead();
    set_encoding(ucc_pkg::ENC_UTF16LE);
    buf_bytes = '{8'hFF, 8'hFE, 8'h3D, 8'hD8};
    send_buffer();
  endtask

  task automatic test_utf32_mark();
    set_encoding(ucc_pkg::ENC_UTF32BE);
    buf_bytes = '{8'h00, 8'h00, 8'hFE, 8'hFF, 8'h00, 8'h01, 8'hF6, 8'h00};
    send_buffer();
  endtask

  task automatic test_drained_restart();
    set_encoding(ucc_pkg::ENC_UTF16BE);
    repeat (4) begin
      compose_buffer(ucc_pkg::ENC_UTF16BE);
      send_buffer();
      wait_idle();
    end
  endtask

  task automatic test_random_buffers();
    logic [2:0] enc;
    int         sent;
    int         target;
    int         phase;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      // every code twice in order, then at random
      enc = (phase < 16) ? ENC_CODES[phase % 8] : ENC_CODES[$urandom_range(0, 7)];
      set_encoding(enc);
      sender_gaps     = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      target = sent + $urandom_range(40, 120);
      while (sent < target) begin
        compose_buffer(enc);
        send_buffer();
        sent += buf_bytes.size();
        if ($urandom_range(0, 15) == 0) wait_idle();
      end
      phase++;
    end
  endtask

  // ---------------- result side ----------------
  always @(negedge clk) begin
    int n;
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      n = pick_gap(receiver_stalls);
      out_ch.ready = (n == 0);
      stall_left   = (n > 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin
    counts_t got;
    counts_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.single_unit_chars, out_ch.double_unit_chars, out_ch.triple_unit_chars,
             out_ch.quad_unit_chars, out_ch.invalid_count, out_ch.mark_bytes};
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected count item: %p", got);
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("count mismatch  expected: %p", want);
            $display("                actual:   %p", got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = ucc_pkg::ENC_NONE;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    stall_left      = 0;
    mismatches      = 0;
    cycle_count     = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    model_enc       = ucc_pkg::ENC_NONE;
    clear_buffer_state();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_single_byte_buffers();
    test_utf8_lengths();
    test_utf16_lone_lead();
    test_utf32_mark();
    test_drained_restart();
    test_random_buffers();

    wait_idle();
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/ucc_pkg.sv
src/ucc_ifs.sv
src/ucc_ctrl.sv
src/ucc_dp.sv
src/unicode_character_counter.sv
bench/tb_top.sv
